FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the demand unit.
// Expects clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWMD_ASSERT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swmd assertion failed");

// Next-cycle implication, disabled during reset.
`define SWMD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swmd assertion failed");

`endif

FILE: rtl/swmd_pkg.sv
// Package of the sliding window max demand unit: sizes, codes, payload types.
// No dependencies.
package swmd_pkg;

  localparam int CHANNELS        = 2;
  localparam int TARIFFS         = 4;
  localparam int WINDOW_MAX      = 30;
  localparam int DEFAULT_MINUTES = 30;
  localparam int FALLBACK_MINUTES =
    (WINDOW_MAX < DEFAULT_MINUTES) ? WINDOW_MAX : DEFAULT_MINUTES;
  localparam int SLOTS      = 1 + TARIFFS;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * WINDOW_MAX;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MAX_DEPTH  = CHANNELS * SLOTS;
  localparam int MAX_AW     = $clog2(MAX_DEPTH);
  localparam int IDX_W      = $clog2(WINDOW_MAX + 1);
  localparam int ACC_W      = 32 + IDX_W;
  localparam int DIV_W      = 40;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int APB_AW     = 3;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_MINUTE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [7:0] COUNT_FULL = 8'hFF;
  localparam logic [7:0] RESET_MINUTES = 8'(DEFAULT_MINUTES);

  typedef enum logic [1:0] {
    K_SAMPLE = 2'd0,
    K_MINUTE = 2'd1,
    K_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        channel;
    logic [31:0] power;
    logic [2:0]  tariff;
    logic [7:0]  stamp_year;
    logic [7:0]  stamp_month;
    logic [7:0]  stamp_day;
    logic [7:0]  stamp_hour;
    logic [7:0]  stamp_minute;
  } in_item_t;

  typedef struct packed {
    logic        out_channel;
    logic [31:0] minute_average;
    logic        demand_valid;
    logic [31:0] demand;
    logic        total_max_new;
    logic        tariff_max_new;
    logic [31:0] total_max;
    logic [31:0] tariff_max;
  } out_item_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_if_t;

endpackage

FILE: rtl/swmd_div.sv
// Restoring divider, one quotient bit per cycle, 40-bit dividend by 8-bit divisor.
// Depends on swmd_pkg.
module swmd_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [swmd_pkg::DIV_W-1:0] dividend,
  input  logic [7:0]               divisor,
  output logic                     busy,
  output logic                     done,
  output logic [swmd_pkg::DIV_W-1:0] quotient,
  output logic [7:0]               remainder
);
  import swmd_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]           dsr;
  logic [8:0]           trial;

  assign trial = {remainder, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= DIV_CNT_W'(DIV_W);
        dsr       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          remainder <= 8'(trial - {1'b0, dsr});
          quotient  <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          remainder <= trial[7:0];
          quotient  <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/swmd_front.sv
// Front end: accepts requests, drops invalid ones (unknown command or channel
// out of range), classifies and queues the rest in a two-entry queue. Depends on swmd_pkg.
module swmd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  swmd_pkg::in_item_t  item,
  output swmd_pkg::job_if_t   job_out,
  input  logic                job_take
);
  import swmd_pkg::*;

  job_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       drop;
  logic       store;
  logic       take;
  kind_t      kind;

  always_comb begin
    drop = (item.cmd != CMD_SAMPLE && item.cmd != CMD_MINUTE && item.cmd != CMD_CLEAR) ||
           (item.cmd != CMD_CLEAR && int'(item.channel) >= CHANNELS);
    unique case (item.cmd)
      CMD_SAMPLE: kind = K_SAMPLE;
      CMD_MINUTE: kind = K_MINUTE;
      default:    kind = K_CLEAR;
    endcase
  end

  assign full  = (count == 2'd2);
  assign store = push && !full && !drop;
  assign take  = job_take && (count != 2'd0);
  assign job_out.valid = (count != 2'd0);
  assign job_out.job   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (store) q[wr_ptr] <= '{kind: kind, item: item};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (store) wr_ptr <= ~wr_ptr;
      if (take)  rd_ptr <= ~rd_ptr;
      if (store && !take)      count <= count + 1'b1;
      else if (take && !store) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/swmd_back.sv
// Back end: sequencer that runs one queued request at a time: accumulation,
// minute average, window ring, window mean and maxima. Depends on swmd_pkg, swmd_div.
`include "assert_macros.svh"
module swmd_back (
  input  logic                clk,
  input  logic                rst,
  input  swmd_pkg::job_if_t   job_in,
  output logic                job_take,
  input  logic [7:0]          window_minutes,
  input  logic [7:0]          slide_minutes,
  output swmd_pkg::out_item_t res,
  output logic                res_valid,
  input  logic                res_pop
);
  import swmd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_CFG  = 12'b0000_0000_0010,
    S_CFGW = 12'b0000_0000_0100,
    S_AVG  = 12'b0000_0000_1000,
    S_AVGW = 12'b0000_0001_0000,
    S_RING = 12'b0000_0010_0000,
    S_MODW = 12'b0000_0100_0000,
    S_SUM  = 12'b0000_1000_0000,
    S_DIVW = 12'b0001_0000_0000,
    S_TOT  = 12'b0010_0000_0000,
    S_TAR  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state;
  job_t   cur;

  logic [7:0]       count    [CHANNELS];
  logic [39:0]      sum      [CHANNELS];
  logic [31:0]      hold     [CHANNELS];
  logic [IDX_W-1:0] widx     [CHANNELS];
  logic             wfull    [CHANNELS];
  logic [31:0]      maxv     [MAX_DEPTH];
  logic [39:0]      maxs     [MAX_DEPTH];
  logic [31:0]      ring     [RING_DEPTH];
  logic             ring_vld [RING_DEPTH];

  logic [IDX_W-1:0] period;
  logic [IDX_W-1:0] slide;
  logic [IDX_W-1:0] j;
  logic             rd_v;
  logic             rd_ok;
  logic [31:0]      rd_data;
  logic [ACC_W-1:0] acc;
  logic [31:0]      demand;
  logic             dvalid;
  logic             tot_new;
  logic             tar_new;
  logic [31:0]      tot_max;
  logic [31:0]      tar_max;

  logic               div_start;
  logic [DIV_W-1:0]   div_a;
  logic [7:0]         div_b;
  logic               div_busy;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [7:0]         div_r;

  logic [CH_IDX_W-1:0] ch;
  logic                tar_ok;
  logic                cfg_pre;
  logic [IDX_W-1:0]    idx0;
  logic [IDX_W-1:0]    idx1;
  logic                full1;
  logic [RING_AW-1:0]  base;
  logic [RING_AW-1:0]  waddr;
  logic [RING_AW-1:0]  raddr;
  logic [MAX_AW-1:0]   slot_tot;
  logic [MAX_AW-1:0]   slot_tar;
  logic [39:0]         stamp;
  logic                new_max;

  swmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  assign job_take = (state == S_IDLE) && job_in.valid;

  always_comb begin
    ch       = CH_IDX_W'(cur.item.channel);
    tar_ok   = (cur.item.tariff != 3'd0) && ({1'b0, cur.item.tariff} <= 4'(TARIFFS));
    cfg_pre  = (window_minutes != 8'd0) && (slide_minutes != 8'd0) &&
               (window_minutes <= 8'(WINDOW_MAX)) && (slide_minutes <= window_minutes);
    base     = RING_AW'(int'(ch) * WINDOW_MAX);
    slot_tot = MAX_AW'(int'(ch) * SLOTS);
    slot_tar = slot_tot + MAX_AW'(cur.item.tariff);
    stamp    = {cur.item.stamp_year, cur.item.stamp_month, cur.item.stamp_day,
                cur.item.stamp_hour, cur.item.stamp_minute};
    raddr    = base + RING_AW'(j);

    // restart the window if the period shrank to or below the index
    idx0  = widx[ch];
    full1 = wfull[ch];
    if (idx0 >= period) begin
      idx0  = '0;
      full1 = 1'b0;
    end
    waddr = base + RING_AW'(idx0);
    idx1  = idx0 + 1'b1;
    if (idx1 == period) begin
      idx1  = '0;
      full1 = 1'b1;
    end

    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    unique case (state)
      S_CFG: begin
        div_start = cfg_pre;
        div_a     = DIV_W'(window_minutes);
        div_b     = slide_minutes;
      end
      S_AVG: begin
        div_start = (count[ch] != 8'd0);
        div_a     = sum[ch];
        div_b     = count[ch];
      end
      S_RING: begin
        div_start = full1;
        div_a     = DIV_W'(idx1);
        div_b     = 8'(slide);
      end
      S_SUM: begin
        div_start = (j == period) && !rd_v;
        div_a     = DIV_W'(acc);
        div_b     = 8'(period);
      end
      default: begin
      end
    endcase

    new_max = 1'b0;
    if (state == S_TOT) new_max = dvalid && (demand > maxv[slot_tot]);
    if (state == S_TAR) new_max = dvalid && tar_ok && (demand > maxv[slot_tar]);
  end

  // window ring storage
  always_ff @(posedge clk) begin
    if (state == S_RING) ring[waddr] <= hold[ch];
    rd_data <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_in.valid) cur <= job_in.job;
    rd_ok <= ring_vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      period    <= IDX_W'(FALLBACK_MINUTES);
      slide     <= IDX_W'(FALLBACK_MINUTES);
      j         <= '0;
      rd_v      <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        count[c] <= '0;
        sum[c]   <= '0;
        hold[c]  <= '0;
        widx[c]  <= '0;
        wfull[c] <= 1'b0;
      end
      for (int k = 0; k < MAX_DEPTH; k++) begin
        maxv[k] <= '0;
        maxs[k] <= '0;
      end
      for (int k = 0; k < RING_DEPTH; k++) ring_vld[k] <= 1'b0;
    end else begin
      if (res_pop && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_in.valid) begin
            unique case (job_in.job.kind)
              K_SAMPLE: begin
                if (count[CH_IDX_W'(job_in.job.item.channel)] != COUNT_FULL) begin
                  count[CH_IDX_W'(job_in.job.item.channel)] <=
                    count[CH_IDX_W'(job_in.job.item.channel)] + 1'b1;
                  sum[CH_IDX_W'(job_in.job.item.channel)] <=
                    sum[CH_IDX_W'(job_in.job.item.channel)] +
                    40'(job_in.job.item.power);
                end
              end
              K_MINUTE: state <= S_CFG;
              default: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  count[c] <= '0;
                  sum[c]   <= '0;
                  hold[c]  <= '0;
                  widx[c]  <= '0;
                  wfull[c] <= 1'b0;
                end
                for (int k = 0; k < MAX_DEPTH; k++) begin
                  maxv[k] <= '0;
                  maxs[k] <= '0;
                end
                for (int k = 0; k < RING_DEPTH; k++) ring_vld[k] <= 1'b0;
              end
            endcase
          end
        end
        S_CFG: begin
          if (cfg_pre) begin
            state <= S_CFGW;
          end else begin
            period <= IDX_W'(FALLBACK_MINUTES);
            slide  <= IDX_W'(FALLBACK_MINUTES);
            state  <= S_AVG;
          end
        end
        S_CFGW: begin
          if (div_done) begin
            if (div_r == 8'd0) begin
              period <= IDX_W'(window_minutes);
              slide  <= IDX_W'(slide_minutes);
            end else begin
              period <= IDX_W'(FALLBACK_MINUTES);
              slide  <= IDX_W'(FALLBACK_MINUTES);
            end
            state <= S_AVG;
          end
        end
        S_AVG: state <= (count[ch] != 8'd0) ? S_AVGW : S_RING;
        S_AVGW: begin
          if (div_done) begin
            hold[ch]  <= div_q[31:0];
            count[ch] <= '0;
            sum[ch]   <= '0;
            state     <= S_RING;
          end
        end
        S_RING: begin
          ring_vld[waddr] <= 1'b1;
          widx[ch]  <= idx1;
          wfull[ch] <= full1;
          dvalid    <= 1'b0;
          demand    <= '0;
          tot_new   <= 1'b0;
          tar_new   <= 1'b0;
          state     <= full1 ? S_MODW : S_TOT;
        end
        S_MODW: begin
          if (div_done) begin
            j    <= '0;
            rd_v <= 1'b0;
            acc  <= '0;
            state <= (div_r == 8'd0) ? S_SUM : S_TOT;
          end
        end
        S_SUM: begin
          if (j != period) begin
            j    <= j + 1'b1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v) acc <= acc + ACC_W'(rd_ok ? rd_data : 32'd0);
          if (j == period && !rd_v) state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            demand <= div_q[31:0];
            dvalid <= 1'b1;
            state  <= S_TOT;
          end
        end
        S_TOT: begin
          if (new_max) begin
            maxv[slot_tot] <= demand;
            maxs[slot_tot] <= stamp;
          end
          tot_new <= new_max;
          tot_max <= new_max ? demand : maxv[slot_tot];
          state   <= S_TAR;
        end
        S_TAR: begin
          if (new_max) begin
            maxv[slot_tar] <= demand;
            maxs[slot_tar] <= stamp;
          end
          tar_new <= new_max;
          tar_max <= !tar_ok ? 32'd0 : (new_max ? demand : maxv[slot_tar]);
          state   <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!res_valid || res_pop) begin
            res_valid <= 1'b1;
            res <= '{out_channel:    cur.item.channel,
                     minute_average: hold[ch],
                     demand_valid:   dvalid,
                     demand:         demand,
                     total_max_new:  tot_new,
                     tariff_max_new: tar_new,
                     total_max:      tot_max,
                     tariff_max:     tar_max};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SWMD_ASSERT(a_div_start_idle, div_start, !div_busy)
  `SWMD_ASSERT_NEXT(a_out_hold, state == S_OUT && res_valid && !res_pop, state == S_OUT && res_valid)
  `SWMD_ASSERT(a_sum_bound, state == S_SUM, j <= period)
  `SWMD_ASSERT(a_new_needs_demand, res_valid, res.demand_valid || !(res.total_max_new || res.tariff_max_new))

endmodule

FILE: rtl/sliding_window_max_demand_unit.sv
// Sliding window maximum demand unit, top level.
// Requests enter through a queue port (push/full, item): a second sample, a
// minute boundary or a clear. Results leave through a queue port (empty/pop,
// result): one result per minute boundary, none for the other requests.
// The APB port sets window_minutes (address 0) and slide_minutes (address 4);
// write them only while the unit is idle.
// A sample or clear is handled in the back end's idle state. A minute boundary
// makes up to four passes of the shared bit-serial divider (setting check,
// minute average, slide phase, window mean) plus one read per window minute
// through the single ring read port; out-of-range settings, no samples and a
// window not yet full skip every pass. The two-entry request queue takes new
// requests while a minute boundary runs.
// Reset clears all sums, counts, ring valid flags, maxima and the queues, and
// sets both settings to 30. When the receiver stalls the result stays in the
// output register; the back end waits before writing the next one and the
// request queue fills, then full rises.
// Depends on swmd_pkg, swmd_front, swmd_back, swmd_div.
module sliding_window_max_demand_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  swmd_pkg::in_item_t                 item,
  output logic                               empty,
  input  logic                               pop,
  output swmd_pkg::out_item_t                result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swmd_pkg::APB_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import swmd_pkg::*;

  logic [7:0] window_minutes;
  logic [7:0] slide_minutes;
  job_if_t    job;
  logic       job_take;
  logic       res_valid;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, slide_minutes} : {24'd0, window_minutes};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_minutes <= RESET_MINUTES;
      slide_minutes  <= RESET_MINUTES;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) slide_minutes  <= pwdata[7:0];
      else          window_minutes <= pwdata[7:0];
    end
  end

  swmd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .job_out (job),
    .job_take(job_take)
  );

  swmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_in        (job),
    .job_take      (job_take),
    .window_minutes(window_minutes),
    .slide_minutes (slide_minutes),
    .res           (result),
    .res_valid     (res_valid),
    .res_pop       (pop)
  );

  assign empty = !res_valid;

endmodule
